[rtl/core/fastest_tracking_differentiator_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tracking differentiator
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FASTEST_TRACKING_DIFFERENTIATOR_TOP_DEFINES_SVH
`define FASTEST_TRACKING_DIFFERENTIATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define FTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ftd assertion failed");
// checked at every edge, reset included
`define FTD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("ftd assertion failed");
`else
`define FTD_ASSERT(lbl, prop)
`define FTD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/ftd_pkg.sv]
// ----------------------------------------------------------------------------
// ftd_pkg
// Shared widths, codes and unit request types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ftd_pkg;
  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned MulW   = 48;   // shared multiplier operand width
  localparam int unsigned MulPW  = 96;
  localparam int unsigned DivNW  = 76;   // numerator width (magnitude << FracW)
  localparam int unsigned DivDW  = 40;
  localparam int unsigned DivQW  = 64;
  localparam int unsigned SqrtRW = 82;   // radicand width
  localparam int unsigned SqrtOW = 41;

  typedef enum logic [1:0] {
    CFG_SPEED  = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_FILTER = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_H0, ST_D, ST_D0, ST_Y, ST_SEL, ST_LDIV, ST_RY, ST_DD,
    ST_SQRT, ST_FSEL, ST_FDIV, ST_FMUL, ST_X1, ST_X2, ST_DONE
  } state_e;

  typedef struct packed {
    logic            start;
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] num;
    logic [DivDW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              start;
    logic [SqrtRW-1:0] rad;
  } sqrt_req_t;
endpackage
`default_nettype wire

[rtl/core/ftd_mul.sv]
// ----------------------------------------------------------------------------
// ftd_mul
// Unsigned 48x48 multiplier, one 16-bit digit of b per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ftd_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ftd_pkg::mul_req_t              req_i,
  output logic                           done_o,
  output logic [ftd_pkg::MulPW-1:0]      prod_o
);
  logic [ftd_pkg::MulW-1:0]  a_q, b_q;
  logic [ftd_pkg::MulPW-1:0] acc_q;
  logic [1:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [63:0]               pp;

  assign pp = 64'(a_q) * 64'(b_q[47:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd2;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 2'd1;
        if (cnt_q == 2'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[79:0], 16'h0} + {32'h0, pp};
      b_q   <= {b_q[31:0], 16'h0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule
`default_nettype wire

[rtl/core/ftd_div.sv]
// ----------------------------------------------------------------------------
// ftd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ftd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ftd_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [ftd_pkg::DivQW-1:0]   quo_o
);
  logic [ftd_pkg::DivNW-1:0] num_q;
  logic [ftd_pkg::DivDW-1:0] den_q, rem_q;
  logic [ftd_pkg::DivQW-1:0] quo_q;
  logic [6:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [ftd_pkg::DivDW:0]   rem_sh, diff;
  logic                      ge;

  assign rem_sh = {rem_q, num_q[ftd_pkg::DivNW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(ftd_pkg::DivNW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[ftd_pkg::DivNW-2:0], 1'b0};
      rem_q <= ge ? diff[ftd_pkg::DivDW-1:0] : rem_sh[ftd_pkg::DivDW-1:0];
      quo_q <= {quo_q[ftd_pkg::DivQW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

[rtl/core/ftd_sqrt.sv]
// ----------------------------------------------------------------------------
// ftd_sqrt
// Floor square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ftd_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ftd_pkg::sqrt_req_t           req_i,
  output logic                         done_o,
  output logic [ftd_pkg::SqrtOW-1:0]   root_o
);
  logic [ftd_pkg::SqrtRW-1:0] rad_q;
  logic [ftd_pkg::SqrtOW-1:0] root_q;
  logic [ftd_pkg::SqrtOW+1:0] rem_q;
  logic [5:0]                 cnt_q;
  logic                       busy_q, done_q;
  logic [ftd_pkg::SqrtOW+3:0] rem_sh, trial, diff;
  logic                       ge;

  assign rem_sh = {rem_q, rad_q[ftd_pkg::SqrtRW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(ftd_pkg::SqrtOW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[ftd_pkg::SqrtRW-3:0], 2'b00};
      rem_q  <= ge ? diff[ftd_pkg::SqrtOW+1:0] : rem_sh[ftd_pkg::SqrtOW+1:0];
      root_q <= {root_q[ftd_pkg::SqrtOW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

[rtl/core/fastest_tracking_differentiator_top.sv]
// ----------------------------------------------------------------------------
// fastest_tracking_differentiator_top
// Second-order tracking differentiator (fhan synthesis), Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o, reference_i): one signed Q16.16
//    sample per transfer. in_ready_o is high only while the sequencer idles.
//  - Output channel (out_valid_o/out_ready_i): one transfer per sample with
//    the new tracked value x1, rate x2 and the fhan acceleration fh.
//  - Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i):
//    index 0 speed r, 1 step h, 2 filter factor N0; always ready. Write it
//    only while no sample is in flight. Other indexes are ignored.
//  - Input transfer to out_valid_o is shortest on the nonlinear branch with fh
//    saturated and longest on the linear branch plus the fh division. It is set
//    by the bit-serial divider (up to two per sample), the square root and the
//    48x48 multiplier (six to nine products). One sample at a time: in_ready_o
//    rises again in the same cycle as out_valid_o.
//  - Reset clears x1, x2 and loads r = 100.0, h = 131/65536, N0 = 1.
//  - A finished result sits in the output register; the next sample is taken
//    while it waits. If the receiver still stalls when the following result
//    is ready, the sequencer holds in its final state and state is untouched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fastest_tracking_differentiator_top_defines.svh"
module fastest_tracking_differentiator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] reference_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] tracked_value_o,
  output logic signed [31:0] tracked_rate_o,
  output logic signed [31:0] tracked_accel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;

  // symmetric saturation to +-(2^31-1)
  function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
    logic signed [31:0] res;
    if (s > 34'(SatMax)) res = SatMax;
    else if (s < -34'(SatMax)) res = -SatMax;
    else res = s[31:0];
    return res;
  endfunction

  // config
  logic [30:0] r_q;
  logic [16:0] h_q;
  logic [7:0]  n0_q;

  // sequencer state and working registers
  ftd_pkg::state_e    state_q, state_d;
  logic               wait_q, wait_d;
  logic signed [31:0] x1_q, x2_q, v_q, v_d;
  logic signed [31:0] x1n_q, x1n_d, x2n_q, x2n_d, fh_q, fh_d;
  logic [24:0]        h0_q, h0_d;
  logic [39:0]        d_q, d_d;
  logic [48:0]        d0_q, d0_d;
  logic signed [43:0] y_q, y_d;
  logic signed [59:0] a_q, a_d;
  logic [16:0]        qf_q, qf_d;
  logic [81:0]        rad_q, rad_d;

  // output register
  logic               out_valid_q;
  logic signed [31:0] tv_q, tr_q, ta_q;
  logic               load_out;

  // shared units
  ftd_pkg::mul_req_t  mul_req;
  ftd_pkg::div_req_t  div_req;
  ftd_pkg::sqrt_req_t sqrt_req;
  logic               mul_done, div_done, sqrt_done;
  logic [95:0]        mul_p;
  logic [63:0]        div_q;
  logic [40:0]        sqrt_root;

  // magnitudes
  logic [43:0]        ay;
  logic [59:0]        aa;
  logic [31:0]        ax2, afh;
  logic               in_fire;

  assign ay  = y_q[43] ? 44'(-y_q) : 44'(y_q);
  assign aa  = a_q[59] ? 60'(-a_q) : 60'(a_q);
  assign ax2 = x2_q[31] ? 32'(-x2_q) : 32'(x2_q);
  assign afh = fh_q[31] ? 32'(-fh_q) : 32'(fh_q);

  assign in_ready_o  = (state_q == ftd_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  ftd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  ftd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  ftd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q  <= 31'd6553600;
      h_q  <= 17'd131;
      n0_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ftd_pkg::cfg_idx_e'(cfg_index_i))
        ftd_pkg::CFG_SPEED:  r_q  <= cfg_data_i[30:0];
        ftd_pkg::CFG_STEP:   h_q  <= cfg_data_i[16:0];
        ftd_pkg::CFG_FILTER: n0_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer: each unit state issues start once, then waits for done
  always_comb begin
    logic signed [43:0] p44;
    logic [39:0]        half;
    logic signed [59:0] sh60;
    logic signed [31:0] m32;
    logic signed [33:0] p34;

    state_d  = state_q;
    wait_d   = wait_q;
    v_d      = v_q;
    h0_d     = h0_q;
    d_d      = d_q;
    d0_d     = d0_q;
    y_d      = y_q;
    a_d      = a_q;
    qf_d     = qf_q;
    rad_d    = rad_q;
    fh_d     = fh_q;
    x1n_d    = x1n_q;
    x2n_d    = x2n_q;
    load_out = 1'b0;
    mul_req  = '0;
    div_req  = '0;
    sqrt_req = '0;
    p44      = '0;
    half     = '0;
    sh60     = '0;
    m32      = '0;
    p34      = '0;

    unique case (state_q)
      ftd_pkg::ST_IDLE: begin
        if (in_fire) begin
          v_d     = (reference_i == -SatMax - 32'sd1) ? -SatMax : reference_i;
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_H0;
        end
      end
      ftd_pkg::ST_H0: begin
        mul_req = '{start: !wait_q, a: 48'(n0_q), b: 48'(h_q)};
        wait_d  = 1'b1;
        if (mul_done) begin
          h0_d    = mul_p[24:0];
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_D;
        end
      end
      ftd_pkg::ST_D: begin
        mul_req = '{start: !wait_q, a: 48'(r_q), b: 48'(h0_q)};
        wait_d  = 1'b1;
        if (mul_done) begin
          d_d     = mul_p[55:16];
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_D0;
        end
      end
      ftd_pkg::ST_D0: begin
        mul_req = '{start: !wait_q, a: 48'(h0_q), b: 48'(d_q)};
        wait_d  = 1'b1;
        if (mul_done) begin
          d0_d    = mul_p[64:16];
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_Y;
        end
      end
      ftd_pkg::ST_Y: begin
        // y = x1 - v + h0*x2
        mul_req = '{start: !wait_q, a: 48'(h0_q), b: 48'(ax2)};
        wait_d  = 1'b1;
        if (mul_done) begin
          p44     = $signed({4'b0, mul_p[55:16]});
          y_d     = 44'(x1_q) - 44'(v_q) + (x2_q[31] ? -p44 : p44);
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_SEL;
        end
      end
      ftd_pkg::ST_SEL: begin
        // boundary |y| == d0 goes nonlinear
        if ({5'b0, ay} < d0_q) state_d = ftd_pkg::ST_LDIV;
        else state_d = ftd_pkg::ST_RY;
      end
      ftd_pkg::ST_LDIV: begin
        div_req = '{start: !wait_q, num: 76'({ay, 16'h0}), den: 40'(h0_q)};
        wait_d  = 1'b1;
        if (div_done) begin
          sh60    = $signed({2'b0, div_q[57:0]});
          a_d     = 60'(x2_q) + (y_q[43] ? -sh60 : sh60);
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_FSEL;
        end
      end
      ftd_pkg::ST_RY: begin
        mul_req = '{start: !wait_q, a: 48'(r_q), b: 48'(ay)};
        wait_d  = 1'b1;
        if (mul_done) begin
          rad_d   = 82'({mul_p[76:0], 3'b000});
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_DD;
        end
      end
      ftd_pkg::ST_DD: begin
        mul_req = '{start: !wait_q, a: 48'(d_q), b: 48'(d_q)};
        wait_d  = 1'b1;
        if (mul_done) begin
          rad_d   = mul_p[81:0] + rad_q;
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_SQRT;
        end
      end
      ftd_pkg::ST_SQRT: begin
        sqrt_req = '{start: !wait_q, rad: rad_q};
        wait_d   = 1'b1;
        if (sqrt_done) begin
          half = (sqrt_root > {1'b0, d_q}) ?
                 40'((sqrt_root - {1'b0, d_q}) >> 1) : 40'd0;
          sh60 = $signed({20'b0, half});
          if (y_q > 44'sd0) a_d = 60'(x2_q) + sh60;
          else if (y_q < 44'sd0) a_d = 60'(x2_q) - sh60;
          else a_d = 60'(x2_q);
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_FSEL;
        end
      end
      ftd_pkg::ST_FSEL: begin
        // boundary |a| == d saturates
        if (aa < {20'b0, d_q}) begin
          state_d = ftd_pkg::ST_FDIV;
        end else begin
          if (a_q > 60'sd0) fh_d = -$signed({1'b0, r_q});
          else if (a_q < 60'sd0) fh_d = $signed({1'b0, r_q});
          else fh_d = '0;
          state_d = ftd_pkg::ST_X1;
        end
      end
      ftd_pkg::ST_FDIV: begin
        div_req = '{start: !wait_q, num: 76'({aa, 16'h0}), den: d_q};
        wait_d  = 1'b1;
        if (div_done) begin
          qf_d    = div_q[16:0];
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_FMUL;
        end
      end
      ftd_pkg::ST_FMUL: begin
        mul_req = '{start: !wait_q, a: 48'(r_q), b: 48'(qf_q)};
        wait_d  = 1'b1;
        if (mul_done) begin
          m32     = $signed({1'b0, mul_p[46:16]});
          fh_d    = a_q[59] ? m32 : -m32;
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_X1;
        end
      end
      ftd_pkg::ST_X1: begin
        mul_req = '{start: !wait_q, a: 48'(h_q), b: 48'(ax2)};
        wait_d  = 1'b1;
        if (mul_done) begin
          p34     = $signed({2'b0, mul_p[47:16]});
          x1n_d   = sat32(34'(x1_q) + (x2_q[31] ? -p34 : p34));
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_X2;
        end
      end
      ftd_pkg::ST_X2: begin
        mul_req = '{start: !wait_q, a: 48'(h_q), b: 48'(afh)};
        wait_d  = 1'b1;
        if (mul_done) begin
          p34     = $signed({2'b0, mul_p[47:16]});
          x2n_d   = sat32(34'(x2_q) + (fh_q[31] ? -p34 : p34));
          wait_d  = 1'b0;
          state_d = ftd_pkg::ST_DONE;
        end
      end
      ftd_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ftd_pkg::ST_IDLE;
        end
      end
      default: state_d = ftd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ftd_pkg::ST_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      x1_q        <= '0;
      x2_q        <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
        x1_q        <= x1n_q;
        x2_q        <= x2n_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    h0_q  <= h0_d;
    d_q   <= d_d;
    d0_q  <= d0_d;
    y_q   <= y_d;
    a_q   <= a_d;
    qf_q  <= qf_d;
    rad_q <= rad_d;
    fh_q  <= fh_d;
    x1n_q <= x1n_d;
    x2n_q <= x2n_d;
    if (load_out) begin
      tv_q <= x1n_q;
      tr_q <= x2n_q;
      ta_q <= fh_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tracked_value_o = tv_q;
  assign tracked_rate_o  = tr_q;
  assign tracked_accel_o = ta_q;

  // at most one shared unit is launched per cycle
  `FTD_ASSERT(a_one_start, $onehot0({mul_req.start, div_req.start, sqrt_req.start}))
  // a stalled result is never overwritten
  `FTD_ASSERT(a_no_overwrite, out_valid_o && !out_ready_i |=> $stable(tracked_value_o))
  // accepting a sample closes the input until the sequence ends
  `FTD_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)
  // a unit is waited on only outside idle
  `FTD_ASSERT(a_wait_not_idle, wait_q |-> state_q != ftd_pkg::ST_IDLE)
  // nothing is presented right after a reset edge
  `FTD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o)
endmodule
`default_nettype wire
